>>> rtl/tcr_pkg.sv
// Types, constants and codes shared by the TCP connection responder.
`timescale 1ns / 1ps
`default_nettype none
package tcr_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SLOT_W = 4;

  localparam logic [1:0] PH_FREE    = 2'd0;
  localparam logic [1:0] PH_SYNRCVD = 2'd1;
  localparam logic [1:0] PH_ESTAB   = 2'd2;
  localparam logic [1:0] PH_LASTACK = 2'd3;

  localparam logic [2:0] OC_OPENED  = 3'd0;
  localparam logic [2:0] OC_FULL    = 3'd1;
  localparam logic [2:0] OC_NOCONN  = 3'd2;
  localparam logic [2:0] OC_ESTAB   = 3'd3;
  localparam logic [2:0] OC_BADACK  = 3'd4;
  localparam logic [2:0] OC_ECHO    = 3'd5;
  localparam logic [2:0] OC_CLOSED  = 3'd6;
  localparam logic [2:0] OC_IGNORED = 3'd7;

  localparam logic [15:0] WINDOW_RESET = 16'hFFFF;

  typedef struct packed {
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_in;
    logic [31:0] ack_in;
    logic        syn_flag;
    logic        fin_flag;
    logic [15:0] ip_total_length;
    logic [3:0]  ip_header_words;
    logic [3:0]  tcp_header_words;
    logic [15:0] ip_ident;
  } tcr_in_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic        reply_valid;
    logic        reply_syn;
    logic        reply_ack_flag;
    logic        reply_fin;
    logic        reply_psh;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack_number;
    logic [15:0] reply_window;
    logic [15:0] reply_payload_length;
    logic [15:0] reply_ip_ident;
    logic [3:0]  connection_slot;
  } tcr_out_t;

  // Lookup wave that travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             syn_found;
    logic [IDX_W-1:0] syn_idx;
    logic [31:0]      syn_exp;
    logic             oth_found;
    logic [IDX_W-1:0] oth_idx;
    logic [1:0]       oth_phase;
    logic [31:0]      oth_exp;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } tcr_wave_t;

  typedef enum logic [1:0] {
    WOP_ALLOC,
    WOP_PHASE,
    WOP_UPDATE
  } tcr_wop_e;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    tcr_wop_e         op;
    logic [1:0]       phase;
    logic [31:0]      exp;
  } tcr_wr_t;

endpackage
`default_nettype wire

>>> rtl/tcp_connection_responder.sv
// Top level of the TCP passive-open connection responder.
// Each received segment header is one item and gives one result item. The
// table entries form a row of cells; a lookup wave passes one cell per
// cycle, through the start register and then each cell register in turn,
// and the result is registered once the wave leaves the last cell. It is
// held until out_ready_i. One item is in flight at a time, and the next
// item is accepted only after the result has been taken. The window
// register may be written whenever no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
module tcp_connection_responder (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tcr_pkg::tcr_in_t  in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tcr_pkg::tcr_out_t      out_item_o,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_wdata_i
);
  import tcr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [15:0] win_q;
  tcr_in_t     item_q;
  logic [15:0] plen_q;
  logic        start_q;
  tcr_out_t    out_q, out_d;
  tcr_wr_t     wr;
  tcr_wave_t   wave_head;
  tcr_wave_t   wave [TABLE_ENTRIES+1];
  tcr_wave_t   res;
  logic [6:0]  hdr;
  logic        in_acc;
  logic        fin;
  logic [31:0] ack_plus;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_item_o  = out_q;

  assign hdr = {1'b0, in_item_i.ip_header_words, 2'b00} +
               {1'b0, in_item_i.tcp_header_words, 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
      plen_q <= (in_item_i.ip_total_length > {9'd0, hdr}) ?
                in_item_i.ip_total_length - {9'd0, hdr} : 16'd0;
    end
  end

  always_comb begin
    wave_head       = '0;
    wave_head.valid = start_q;
  end

  assign wave[0] = wave_head;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    tcr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .key_i      (item_q),
      .wr_i       (wr),
      .wave_i     (wave[i]),
      .wave_o     (wave[i+1])
    );
  end

  assign res      = wave[TABLE_ENTRIES];
  assign fin      = item_q.fin_flag;
  assign ack_plus = item_q.ack_in + {16'd0, plen_q} + {31'd0, fin};

  // Decide the action once the wave has passed the last cell.
  always_comb begin
    state_d = state_q;
    out_d   = out_q;
    wr      = '0;
    wr.op   = WOP_PHASE;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SCAN;
      ST_SCAN: begin
        if (res.valid) begin
          state_d = ST_OUT;
          out_d   = '0;
          if (item_q.syn_flag) begin
            if (!res.free_found) begin
              out_d.outcome = OC_FULL;
            end else begin
              wr.en    = 1'b1;
              wr.idx   = res.free_idx;
              wr.op    = WOP_ALLOC;
              wr.phase = PH_SYNRCVD;
              wr.exp   = 32'd1;
              out_d.outcome          = OC_OPENED;
              out_d.reply_valid      = 1'b1;
              out_d.reply_syn        = 1'b1;
              out_d.reply_ack_flag   = 1'b1;
              out_d.reply_ack_number = item_q.seq_in + 32'd1;
              out_d.reply_window     = win_q;
              out_d.reply_ip_ident   = item_q.ip_ident;
              out_d.connection_slot  = SLOT_W'(res.free_idx);
            end
          end else if (res.syn_found) begin
            wr.en  = 1'b1;
            wr.idx = res.syn_idx;
            out_d.connection_slot = SLOT_W'(res.syn_idx);
            if (item_q.ack_in == res.syn_exp) begin
              wr.phase      = PH_ESTAB;
              out_d.outcome = OC_ESTAB;
            end else begin
              wr.phase      = PH_FREE;
              out_d.outcome = OC_BADACK;
            end
          end else if (res.oth_found) begin
            out_d.connection_slot = SLOT_W'(res.oth_idx);
            wr.idx = res.oth_idx;
            if (res.oth_phase == PH_ESTAB) begin
              wr.en    = 1'b1;
              wr.op    = WOP_UPDATE;
              wr.exp   = ack_plus;
              wr.phase = fin ? PH_LASTACK : PH_ESTAB;
              out_d.outcome              = OC_ECHO;
              out_d.reply_valid          = 1'b1;
              out_d.reply_ack_flag       = 1'b1;
              out_d.reply_fin            = fin;
              out_d.reply_psh            = 1'b1;
              out_d.reply_seq            = item_q.ack_in;
              out_d.reply_ack_number     = item_q.seq_in + {16'd0, plen_q} + {31'd0, fin};
              out_d.reply_window         = win_q;
              out_d.reply_payload_length = plen_q;
              out_d.reply_ip_ident       = item_q.ip_ident;
            end else if (item_q.ack_in == res.oth_exp) begin
              wr.en         = 1'b1;
              wr.phase      = PH_FREE;
              out_d.outcome = OC_CLOSED;
            end else begin
              out_d.outcome = OC_IGNORED;
            end
          end else begin
            out_d.outcome = OC_NOCONN;
          end
        end
      end
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // A result shows up only after the wave has left the last cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(res.valid))
    else $error("result without completed lookup");

  // Outcomes without a reply carry an all-zero window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.reply_valid) |-> (out_item_o.reply_window == 16'd0))
    else $error("reply fields set without reply");

  // A full table or a missing connection never replies.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.outcome == OC_FULL || out_item_o.outcome == OC_NOCONN))
      |-> (!out_item_o.reply_valid && out_item_o.connection_slot == '0))
    else $error("reply or slot on failed lookup");

endmodule
`default_nettype wire

>>> rtl/tcr_cell.sv
// One connection table entry with its step of the lookup wave.
`timescale 1ns / 1ps
`default_nettype none
module tcr_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [tcr_pkg::IDX_W-1:0] cell_idx_i,
  input  wire tcr_pkg::tcr_in_t        key_i,
  input  wire tcr_pkg::tcr_wr_t        wr_i,
  input  wire tcr_pkg::tcr_wave_t      wave_i,
  output tcr_pkg::tcr_wave_t           wave_o
);
  import tcr_pkg::*;

  logic [1:0]  phase_q;
  logic [31:0] peer_ip_q, own_ip_q, exp_q;
  logic [15:0] peer_port_q, own_port_q;
  logic        match;
  logic        sel;
  tcr_wave_t   wave_d, wave_q;

  assign match = (peer_ip_q == key_i.source_ip) && (own_ip_q == key_i.dest_ip) &&
                 (peer_port_q == key_i.source_port) && (own_port_q == key_i.dest_port);
  assign sel = wr_i.en && (wr_i.idx == cell_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FREE;
    end else if (sel) begin
      phase_q <= wr_i.phase;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel) begin
      unique case (wr_i.op)
        WOP_ALLOC: begin
          peer_ip_q   <= key_i.source_ip;
          own_ip_q    <= key_i.dest_ip;
          peer_port_q <= key_i.source_port;
          own_port_q  <= key_i.dest_port;
          exp_q       <= wr_i.exp;
        end
        WOP_UPDATE: exp_q <= wr_i.exp;
        default: ;
      endcase
    end
  end

  always_comb begin
    wave_d = wave_i;
    if (wave_i.valid) begin
      if (phase_q == PH_SYNRCVD && match && !wave_i.syn_found) begin
        wave_d.syn_found = 1'b1;
        wave_d.syn_idx   = cell_idx_i;
        wave_d.syn_exp   = exp_q;
      end
      if ((phase_q == PH_ESTAB || phase_q == PH_LASTACK) && match && !wave_i.oth_found) begin
        wave_d.oth_found = 1'b1;
        wave_d.oth_idx   = cell_idx_i;
        wave_d.oth_phase = phase_q;
        wave_d.oth_exp   = exp_q;
      end
      if (phase_q == PH_FREE && !wave_i.free_found) begin
        wave_d.free_found = 1'b1;
        wave_d.free_idx   = cell_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  assign wave_o = wave_q;

endmodule
`default_nettype wire
